// ===== rtl/ordered_array_insert_delete_core_assert.svh =====
// Assertion macros used by the RTL of the ordered list block.
`ifndef ORDERED_ARRAY_INSERT_DELETE_CORE_ASSERT_SVH
`define ORDERED_ARRAY_INSERT_DELETE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OAID_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: invariant violated");

// The consequent must hold in the cycle after the antecedent.
`define OAID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: sequence violated");

`endif

// ===== rtl/oaid_pkg.sv =====
`timescale 1ns / 1ps

package oaid_pkg;

  localparam int DATA_W    = 32;
  localparam int POS_W     = 4;
  localparam int CNT_OUT_W = 5;
  localparam int ST_W      = 2;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_POS  = 2'd2
  } status_t;

  // What every cell does in the current cycle.
  typedef enum logic [1:0] {
    CM_HOLD    = 2'd0,
    CM_APPEND  = 2'd1,
    CM_INSERT  = 2'd2,
    CM_COMPACT = 2'd3
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       keep;
  } cell_ctrl_t;

endpackage

// ===== rtl/oaid_cell.sv =====
`timescale 1ns / 1ps

module oaid_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                           clk,
  input  oaid_pkg::cell_ctrl_t           ctrl_i,
  input  logic [CW-1:0]                  count_i,
  input  logic [CW-1:0]                  pos_i,
  input  logic [CW-1:0]                  tail_i,
  input  logic [oaid_pkg::DATA_W-1:0]    value_i,
  input  logic [oaid_pkg::DATA_W-1:0]    head_i,
  input  logic [oaid_pkg::DATA_W-1:0]    left_i,
  input  logic [oaid_pkg::DATA_W-1:0]    right_i,
  output logic [oaid_pkg::DATA_W-1:0]    data_o
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic [oaid_pkg::DATA_W-1:0] entry_r;
  logic [oaid_pkg::DATA_W-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    unique case (ctrl_i.mode)
      oaid_pkg::CM_HOLD: begin
        entry_nxt = entry_r;
      end
      oaid_pkg::CM_APPEND: begin
        if (MY_IDX == count_i) begin
          entry_nxt = value_i;
        end
      end
      oaid_pkg::CM_INSERT: begin
        if (MY_IDX == pos_i) begin
          entry_nxt = value_i;
        end else if ((MY_IDX > pos_i) && (MY_IDX <= count_i)) begin
          entry_nxt = left_i;
        end
      end
      oaid_pkg::CM_COMPACT: begin
        // The list rotates toward cell 0; a kept head word re-enters at the tail
        // of the live region, a matching one simply drops out.
        if (ctrl_i.keep && (MY_IDX == tail_i)) begin
          entry_nxt = head_i;
        end else begin
          entry_nxt = right_i;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign data_o = entry_r;

endmodule

// ===== rtl/ordered_array_insert_delete_core.sv =====
`timescale 1ns / 1ps
// Ordered list of up to DEPTH signed 32-bit words held in a chain of cells.
// Input channel (in_valid / in_stall): opcode, value, position. Every accepted
// word yields exactly one result word on the output channel (out_valid /
// out_stall): read value, entry count, removed count and status.
// Append, insert and read finish in the accept cycle; their result passes
// through the result buffer into the output register, and such words may be
// accepted one per cycle while the output does not stall.
// Delete walks the list through the chain, one entry per cycle, over the N
// entries counted at acceptance (0 to DEPTH), and holds the input until the
// walk ends; its result then passes through the result buffer.
// A result buffer sits in front of the output register, so one new word is
// taken while an earlier result waits. When out_stall is high the output word
// holds, and in_stall rises once the buffer is also full.
// Reset clears the entry count and both valid flags; the cell contents are
// left as they are and are never returned before being written.
// Only positions 0 to 15 are reachable through the position field.

`include "ordered_array_insert_delete_core_assert.svh"

module ordered_array_insert_delete_core #(
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_opcode,
  input  logic signed [oaid_pkg::DATA_W-1:0]   in_value,
  input  logic [oaid_pkg::POS_W-1:0]           in_position,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [oaid_pkg::DATA_W-1:0]   out_read_value,
  output logic [oaid_pkg::CNT_OUT_W-1:0]       out_entry_count,
  output logic [oaid_pkg::CNT_OUT_W-1:0]       out_removed_count,
  output logic [oaid_pkg::ST_W-1:0]            out_status
);

  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CMP_W = (CW > oaid_pkg::POS_W) ? CW : oaid_pkg::POS_W;
  localparam int RD_N  = (DEPTH < 16) ? DEPTH : 16;
  localparam int RD_W  = $clog2(RD_N);

  typedef enum logic [1:0] {
    S_IDLE    = 2'b01,
    S_COMPACT = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] live_r, live_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic [oaid_pkg::DATA_W-1:0] key_r, key_nxt;

  logic                        res_valid_r, res_valid_nxt;
  logic [oaid_pkg::DATA_W-1:0] res_rd_r, res_rd_nxt;
  logic [CW-1:0]               res_cnt_r, res_cnt_nxt;
  logic [CW-1:0]               res_rem_r, res_rem_nxt;
  oaid_pkg::status_t           res_st_r, res_st_nxt;
  logic                        res_load;

  logic                        out_valid_r, out_valid_nxt;
  logic [oaid_pkg::DATA_W-1:0] out_rd_r;
  logic [CW-1:0]               out_cnt_r;
  logic [CW-1:0]               out_rem_r;
  oaid_pkg::status_t           out_st_r;

  logic [oaid_pkg::DATA_W-1:0] cell_q [DEPTH];
  logic [oaid_pkg::DATA_W-1:0] rd_tab [RD_N];
  oaid_pkg::cell_ctrl_t        ctrl;
  logic [CW-1:0]               cell_pos;
  logic [CW-1:0]               tail_idx;

  logic             accept;
  logic             res_move;
  logic             full;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             head_keep;
  logic [CW-1:0]    live_after;
  oaid_pkg::op_t    op;

  // Chain of cells: each one sees its two neighbors, the head of the chain
  // and the broadcast control word.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [oaid_pkg::DATA_W-1:0] left_d;
    logic [oaid_pkg::DATA_W-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = in_value;
    end else begin : g_mid_left
      assign left_d = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_q[i];
    end else begin : g_mid_right
      assign right_d = cell_q[i+1];
    end

    oaid_cell #(
      .IDX(i),
      .CW (CW)
    ) u_cell (
      .clk     (clk),
      .ctrl_i  (ctrl),
      .count_i (count_r),
      .pos_i   (cell_pos),
      .tail_i  (tail_idx),
      .value_i (in_value),
      .head_i  (cell_q[0]),
      .left_i  (left_d),
      .right_i (right_d),
      .data_o  (cell_q[i])
    );
  end

  for (genvar k = 0; k < RD_N; k++) begin : g_rd
    assign rd_tab[k] = cell_q[k];
  end

  assign op         = oaid_pkg::op_t'(in_opcode);
  assign res_move   = res_valid_r && (!out_valid_r || !out_stall);
  assign in_stall   = !((state_r == S_IDLE) && (!res_valid_r || res_move));
  assign accept     = in_valid && !in_stall;
  assign full       = (count_r == CW'(DEPTH));
  assign pos_ext    = CMP_W'(in_position);
  assign cnt_ext    = CMP_W'(count_r);
  assign cell_pos   = CW'(in_position);
  assign tail_idx   = live_r - CW'(1);
  assign head_keep  = (cell_q[0] != key_r);
  assign live_after = head_keep ? live_r : (live_r - CW'(1));

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    live_nxt    = live_r;
    scan_nxt    = scan_r;
    key_nxt     = key_r;
    res_load    = 1'b0;
    res_rd_nxt  = '0;
    res_cnt_nxt = count_r;
    res_rem_nxt = '0;
    res_st_nxt  = oaid_pkg::ST_OK;
    ctrl.mode   = oaid_pkg::CM_HOLD;
    ctrl.keep   = head_keep;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_load = 1'b1;
          unique case (op)
            oaid_pkg::OP_APPEND: begin
              if (full) begin
                res_st_nxt = oaid_pkg::ST_FULL;
              end else begin
                ctrl.mode   = oaid_pkg::CM_APPEND;
                count_nxt   = count_r + CW'(1);
                res_cnt_nxt = count_r + CW'(1);
              end
            end
            oaid_pkg::OP_INSERT: begin
              if (full) begin
                res_st_nxt = oaid_pkg::ST_FULL;
              end else if (pos_ext > cnt_ext) begin
                res_st_nxt = oaid_pkg::ST_POS;
              end else begin
                ctrl.mode   = oaid_pkg::CM_INSERT;
                count_nxt   = count_r + CW'(1);
                res_cnt_nxt = count_r + CW'(1);
              end
            end
            oaid_pkg::OP_DELETE: begin
              // An empty list has nothing to walk; answer at once.
              if (count_r != '0) begin
                res_load  = 1'b0;
                key_nxt   = in_value;
                live_nxt  = count_r;
                scan_nxt  = count_r;
                state_nxt = S_COMPACT;
              end
            end
            oaid_pkg::OP_READ: begin
              if (pos_ext >= cnt_ext) begin
                res_st_nxt = oaid_pkg::ST_POS;
              end else begin
                res_rd_nxt = rd_tab[in_position[RD_W-1:0]];
              end
            end
            default: begin
              res_st_nxt = oaid_pkg::ST_OK;
            end
          endcase
        end
      end
      S_COMPACT: begin
        ctrl.mode = oaid_pkg::CM_COMPACT;
        live_nxt  = live_after;
        scan_nxt  = scan_r - CW'(1);
        if (scan_r == CW'(1)) begin
          count_nxt   = live_after;
          res_load    = 1'b1;
          res_cnt_nxt = live_after;
          res_rem_nxt = count_r - live_after;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res_valid_nxt = res_load ? 1'b1 : (res_move ? 1'b0 : res_valid_r);
  assign out_valid_nxt = res_move ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      res_valid_r <= res_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    live_r <= live_nxt;
    scan_r <= scan_nxt;
    key_r  <= key_nxt;
    if (res_load) begin
      res_rd_r  <= res_rd_nxt;
      res_cnt_r <= res_cnt_nxt;
      res_rem_r <= res_rem_nxt;
      res_st_r  <= res_st_nxt;
    end
    if (res_move) begin
      out_rd_r  <= res_rd_r;
      out_cnt_r <= res_cnt_r;
      out_rem_r <= res_rem_r;
      out_st_r  <= res_st_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_value    = out_rd_r;
  assign out_entry_count   = oaid_pkg::CNT_OUT_W'(out_cnt_r);
  assign out_removed_count = oaid_pkg::CNT_OUT_W'(out_rem_r);
  assign out_status        = out_st_r;

  `OAID_ASSERT_NOW(a_count_range, clk, rst_n, 1'b1, count_r <= CW'(DEPTH))
  `OAID_ASSERT_NOW(a_compact_blocks_input, clk, rst_n, state_r == S_COMPACT, in_stall)
  `OAID_ASSERT_NOW(a_compact_bounds, clk, rst_n, state_r == S_COMPACT,
                   (scan_r != '0) && (scan_r <= live_r) && (live_r <= count_r))
  `OAID_ASSERT_NOW(a_compact_buffer_free, clk, rst_n, state_r == S_COMPACT, !res_valid_r)
  `OAID_ASSERT_NEXT(a_buffer_drains, clk, rst_n, res_valid_r && !out_valid_r, out_valid)

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int LIST_DEPTH    = 16;
  localparam int RANDOM_WORDS  = 800;
  localparam int TAIL_WORDS    = 150;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int KEY_COUNT     = 6;

  typedef struct packed {
    oaid_pkg::op_t                opcode;
    logic [oaid_pkg::DATA_W-1:0]  value;
    logic [oaid_pkg::POS_W-1:0]   position;
    logic                         wait_drain;
  } list_cmd_t;

  typedef struct packed {
    logic [oaid_pkg::DATA_W-1:0]    read_value;
    logic [oaid_pkg::CNT_OUT_W-1:0] entry_count;
    logic [oaid_pkg::CNT_OUT_W-1:0] removed_count;
    oaid_pkg::status_t              status;
  } list_result_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [1:0]                         in_opcode = 2'd0;
  logic signed [oaid_pkg::DATA_W-1:0] in_value = '0;
  logic [oaid_pkg::POS_W-1:0]         in_position = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic signed [oaid_pkg::DATA_W-1:0] out_read_value;
  logic [oaid_pkg::CNT_OUT_W-1:0]     out_entry_count;
  logic [oaid_pkg::CNT_OUT_W-1:0]     out_removed_count;
  logic [oaid_pkg::ST_W-1:0]          out_status;

  ordered_array_insert_delete_core #(.DEPTH(LIST_DEPTH)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_value         (in_value),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_value   (out_read_value),
    .out_entry_count  (out_entry_count),
    .out_removed_count(out_removed_count),
    .out_status       (out_status)
  );

  always #10 clk = ~clk;

  // Predicted list contents and length.
  logic [oaid_pkg::DATA_W-1:0] list_mem [LIST_DEPTH];
  int                          list_len = 0;

  list_cmd_t                   pending_cmds [$];
  list_result_t                expected_results [$];
  logic [oaid_pkg::DATA_W-1:0] key_pool [KEY_COUNT];
  logic [oaid_pkg::DATA_W-1:0] stray_keys [$];

  int total_cmds = 0;
  int words_sent = 0;
  int words_accepted = 0;
  int error_count = 0;
  int cyc = 0;
  int quiet_cycles = 0;
  int src_gap = 0;
  int snk_gap = 0;
  int src_odds = 2;
  int snk_odds = 2;

  int op_seen [4] = '{0, 0, 0, 0};
  int full_hits = 0;
  int pos_hits = 0;
  int removing_deletes = 0;
  int peak_len = 0;

  function automatic list_result_t apply_list_op(oaid_pkg::op_t op,
                                                 logic [oaid_pkg::DATA_W-1:0] val, int pos);
    list_result_t r;
    int kept;
    r = '0;
    r.status = oaid_pkg::ST_OK;
    case (op)
      oaid_pkg::OP_APPEND: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = oaid_pkg::ST_FULL;
        end else begin
          list_mem[list_len] = val;
          list_len++;
        end
      end
      oaid_pkg::OP_INSERT: begin
        // The full check wins over the position check.
        if (list_len >= LIST_DEPTH) begin
          r.status = oaid_pkg::ST_FULL;
        end else if (pos > list_len) begin
          r.status = oaid_pkg::ST_POS;
        end else begin
          for (int i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = val;
          list_len++;
        end
      end
      oaid_pkg::OP_DELETE: begin
        kept = 0;
        for (int i = 0; i < list_len; i++) begin
          if (list_mem[i] != val) begin
            list_mem[kept] = list_mem[i];
            kept++;
          end
        end
        r.removed_count = oaid_pkg::CNT_OUT_W'(list_len - kept);
        list_len = kept;
      end
      default: begin
        if (pos >= list_len) begin
          r.status = oaid_pkg::ST_POS;
        end else begin
          r.read_value = list_mem[pos];
        end
      end
    endcase
    r.entry_count = oaid_pkg::CNT_OUT_W'(list_len);
    return r;
  endfunction

  task automatic queue_cmd(oaid_pkg::op_t op, logic [oaid_pkg::DATA_W-1:0] val, int pos,
                           logic drain);
    list_cmd_t c;
    c.opcode = op;
    c.value = val;
    c.position = oaid_pkg::POS_W'(pos);
    c.wait_drain = drain;
    pending_cmds.push_back(c);
    total_cmds++;
  endtask

  function automatic logic [oaid_pkg::DATA_W-1:0] pick_value(output logic stray);
    stray = 1'b0;
    if ($urandom_range(0, 19) == 0) begin
      stray = 1'b1;
      return $urandom();
    end
    return key_pool[$urandom_range(0, KEY_COUNT - 1)];
  endfunction

  // Values outside the key pool are remembered so a later sweep can clear them.
  task automatic queue_random_cmd(oaid_pkg::op_t op);
    logic [oaid_pkg::DATA_W-1:0] val;
    logic stray;
    val = pick_value(stray);
    if (stray && (op == oaid_pkg::OP_APPEND || op == oaid_pkg::OP_INSERT)) begin
      stray_keys.push_back(val);
    end
    queue_cmd(op, val, $urandom_range(0, 15), 1'b0);
  endtask

  function automatic oaid_pkg::op_t mixed_op();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return oaid_pkg::OP_APPEND;
    if (roll < 50) return oaid_pkg::OP_INSERT;
    if (roll < 65) return oaid_pkg::OP_DELETE;
    return oaid_pkg::OP_READ;
  endfunction

  task automatic build_stimulus();
    int n;
    logic [oaid_pkg::DATA_W-1:0] val;
    oaid_pkg::op_t op;
    // Directed opening: empty list, both ends of the value range, middle
    // and end inserts, a full list and a delete that removes many entries.
    queue_cmd(oaid_pkg::OP_READ, 32'd0, 0, 1'b0);
    queue_cmd(oaid_pkg::OP_DELETE, 32'd0, 0, 1'b0);
    queue_cmd(oaid_pkg::OP_INSERT, 32'd1, 1, 1'b0);
    queue_cmd(oaid_pkg::OP_INSERT, 32'h8000_0000, 0, 1'b0);
    queue_cmd(oaid_pkg::OP_APPEND, 32'h7fff_ffff, 0, 1'b0);
    queue_cmd(oaid_pkg::OP_APPEND, 32'hffff_ffff, 15, 1'b0);
    queue_cmd(oaid_pkg::OP_APPEND, 32'd0, 0, 1'b0);
    queue_cmd(oaid_pkg::OP_INSERT, 32'd5, 2, 1'b0);
    queue_cmd(oaid_pkg::OP_INSERT, 32'd6, 5, 1'b0);
    queue_cmd(oaid_pkg::OP_READ, 32'd0, 5, 1'b0);
    queue_cmd(oaid_pkg::OP_READ, 32'd0, 6, 1'b0);
    queue_cmd(oaid_pkg::OP_DELETE, 32'hffff_ffff, 0, 1'b0);
    for (int i = 0; i < 11; i++) queue_cmd(oaid_pkg::OP_APPEND, 32'd7, i, 1'b0);
    queue_cmd(oaid_pkg::OP_APPEND, 32'd8, 0, 1'b0);
    queue_cmd(oaid_pkg::OP_INSERT, 32'd9, 15, 1'b0);
    queue_cmd(oaid_pkg::OP_READ, 32'd0, 15, 1'b0);
    queue_cmd(oaid_pkg::OP_DELETE, 32'd7, 0, 1'b0);

    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    key_pool[4] = $urandom();
    key_pool[5] = $urandom();

    // Let all outstanding results drain completely once before the random part.
    queue_cmd(oaid_pkg::OP_READ, 32'd0, $urandom_range(0, 15), 1'b1);
    n = total_cmds + RANDOM_WORDS;
    while (total_cmds < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          for (int i = $urandom_range(8, 20); i > 0; i--) begin
            if ($urandom_range(0, 2) == 0) begin
              queue_random_cmd(oaid_pkg::OP_INSERT);
            end else begin
              queue_random_cmd(oaid_pkg::OP_APPEND);
            end
          end
        end
        3, 4, 5: begin
          for (int i = $urandom_range(10, 30); i > 0; i--) queue_random_cmd(mixed_op());
        end
        6, 7: begin
          for (int k = 0; k < KEY_COUNT; k++) begin
            queue_cmd(oaid_pkg::OP_DELETE, key_pool[k], $urandom_range(0, 15), 1'b0);
          end
          foreach (stray_keys[k]) queue_cmd(oaid_pkg::OP_DELETE, stray_keys[k], 0, 1'b0);
          stray_keys.delete();
          queue_cmd(oaid_pkg::OP_READ, 32'd0, $urandom_range(0, 15), 1'b0);
        end
        8: begin
          for (int i = $urandom_range(5, 15); i > 0; i--) begin
            op = oaid_pkg::op_t'($urandom_range(0, 3));
            val = $urandom();
            if (op == oaid_pkg::OP_APPEND || op == oaid_pkg::OP_INSERT) begin
              stray_keys.push_back(val);
            end
            queue_cmd(op, val, $urandom_range(0, 15), 1'b0);
          end
        end
        default: begin
          queue_cmd(oaid_pkg::OP_READ, 32'd0, $urandom_range(0, 15), 1'b1);
          for (int i = $urandom_range(5, 15); i > 0; i--) queue_random_cmd(mixed_op());
        end
      endcase
    end
  endtask

  // Input driver: a word stays on the ports until it is taken.
  always @(negedge clk) begin : drive_inputs
    list_cmd_t cmd;
    logic drive_now;
    if (cyc % 64 == 0) src_odds = $urandom_range(0, 3);
    if (rst_n && !(in_valid && (words_accepted < words_sent))) begin
      drive_now = 1'b0;
      if (src_gap > 0) begin
        src_gap--;
      end else if (pending_cmds.size() > 0 &&
                   !(pending_cmds[0].wait_drain && expected_results.size() > 0)) begin
        if (pending_cmds.size() > TAIL_WORDS && $urandom_range(0, 15) < src_odds * 2) begin
          src_gap = $urandom_range(1, 17) - 1;
        end else begin
          cmd = pending_cmds.pop_front();
          in_opcode <= cmd.opcode;
          in_value <= cmd.value;
          in_position <= cmd.position;
          drive_now = 1'b1;
          words_sent++;
        end
      end
      in_valid <= drive_now;
    end
  end

  always @(negedge clk) begin : drive_stall
    if (cyc % 64 == 0) snk_odds = $urandom_range(0, 3);
    if (snk_gap > 0) begin
      snk_gap--;
      out_stall <= 1'b1;
    end else if (rst_n && pending_cmds.size() > TAIL_WORDS &&
                 $urandom_range(0, 15) < snk_odds * 2) begin
      snk_gap = $urandom_range(1, 17) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    list_result_t want;
    list_result_t got;
    list_result_t fresh;
    if (rst_n) begin
      cyc++;
      // Results are checked before this cycle's input word is predicted.
      if (out_valid && !out_stall) begin
        got.read_value = out_read_value;
        got.entry_count = out_entry_count;
        got.removed_count = out_removed_count;
        got.status = oaid_pkg::status_t'(out_status);
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("%0t: unexpected result word rd=%h cnt=%0d rm=%0d st=%0d", $time,
                     got.read_value, got.entry_count, got.removed_count, got.status);
          end
        end else begin
          want = expected_results.pop_front();
          if (got.read_value !== want.read_value || got.entry_count !== want.entry_count ||
              got.removed_count !== want.removed_count || out_status !== want.status) begin
            error_count++;
            if (error_count <= 10) begin
              $display("%0t: mismatch exp rd=%h cnt=%0d rm=%0d st=%0d", $time,
                       want.read_value, want.entry_count, want.removed_count, want.status);
              $display("%0t:          got rd=%h cnt=%0d rm=%0d st=%0d", $time,
                       out_read_value, out_entry_count, out_removed_count, out_status);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        fresh = apply_list_op(oaid_pkg::op_t'(in_opcode), in_value, int'(in_position));
        expected_results.push_back(fresh);
        words_accepted++;
        op_seen[in_opcode]++;
        if (fresh.status == oaid_pkg::ST_FULL) full_hits++;
        if (fresh.status == oaid_pkg::ST_POS) pos_hits++;
        if (fresh.removed_count > 0) removing_deletes++;
        if (int'(fresh.entry_count) > peak_len) peak_len = int'(fresh.entry_count);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    build_stimulus();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (words_accepted < total_cmds) @(negedge clk);
    while (expected_results.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Covered %0d words: %0d append, %0d insert, %0d delete, %0d read.",
             words_accepted, op_seen[oaid_pkg::OP_APPEND], op_seen[oaid_pkg::OP_INSERT],
             op_seen[oaid_pkg::OP_DELETE], op_seen[oaid_pkg::OP_READ]);
    $display("%0d full, %0d bad position, %0d deletes removed entries, peak length %0d.",
             full_hits, pos_hits, removing_deletes, peak_len);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/oaid_pkg.sv
rtl/oaid_cell.sv
rtl/ordered_array_insert_delete_core.sv
tb/sv/tb.sv
